### rtl/core/ues_pkg.sv
// Shared constants, command codes and types of the ultrasonic echo scanner.
package ues_pkg;

	localparam int NUM_SENSORS = 4;
	localparam int SENS_W      = 2;
	localparam int TS_W        = 16;
	localparam int DIST_W      = 11;

	// Divide by 58 as multiply by ceil(2^22 / 58) and shift; exact for 16-bit inputs.
	localparam int ECHO_DIVISOR = 58;
	localparam int DIV_SHIFT    = 22;
	localparam int DIV_MUL_W    = 17;
	localparam logic [DIV_MUL_W-1:0] DIV_MUL =
		DIV_MUL_W'(((64'd1 << DIV_SHIFT) + ECHO_DIVISOR - 1) / ECHO_DIVISOR);

	typedef enum logic [1:0] {
		CMD_TRIGGER = 2'd0,
		CMD_EDGE    = 2'd1,
		CMD_CHECK   = 2'd2,
		CMD_READ    = 2'd3
	} cmd_t;

	typedef struct packed {
		logic              wr;
		logic              commit;
		logic [SENS_W-1:0] slot;
		logic [DIST_W-1:0] data;
	} store_ctl_t;

endpackage

### rtl/core/ues_div58.sv
// Truncating divide of the echo width by 58 through a reciprocal multiply.
module ues_div58 (
	input  logic [ues_pkg::TS_W-1:0]   diff,
	output logic [ues_pkg::DIST_W-1:0] quot
);
	import ues_pkg::*;

	logic [TS_W+DIV_MUL_W-1:0] prod;

	assign prod = (TS_W+DIV_MUL_W)'(diff) * (TS_W+DIV_MUL_W)'(DIV_MUL);
	assign quot = DIST_W'(prod >> DIV_SHIFT);

endmodule

### rtl/core/ues_dist_store.sv
// Sweep buffer and visible distance table; the whole sweep is committed to the table together with its last entry.
module ues_dist_store (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ues_pkg::store_ctl_t        ctl,
	input  logic [ues_pkg::SENS_W-1:0] rd_sel,
	output logic [ues_pkg::DIST_W-1:0] rd_data
);
	import ues_pkg::*;

	logic [DIST_W-1:0] sweep_q [NUM_SENSORS];
	logic [DIST_W-1:0] table_q [NUM_SENSORS];

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			sweep_q[ctl.slot] <= ctl.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SENSORS; i++) begin
				table_q[i] <= '0;
			end
		end else if (ctl.wr && ctl.commit) begin
			for (int i = 0; i < NUM_SENSORS; i++) begin
				table_q[i] <= (SENS_W'(i) == ctl.slot) ? ctl.data : sweep_q[i];
			end
		end
	end

	assign rd_data = (32'(rd_sel) < NUM_SENSORS) ? table_q[rd_sel] : '0;

endmodule

### rtl/core/ultrasonic_echo_scanner_core.sv
// Ultrasonic echo scanner: input register, one-pass command logic, result register.
// An accepted item goes from the input register to the result register unless out_stall holds it.
// Throughput: one item per cycle while out_stall is low; the result register parts the two channels.
// Reset clears control state, the distance table and the result valid;
// the sweep buffer is not cleared.
module ultrasonic_echo_scanner_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 cmd,
	input  logic                       edge_rising,
	input  logic [ues_pkg::TS_W-1:0]   timestamp,
	input  logic [ues_pkg::SENS_W-1:0] sensor,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       trigger_fire,
	output logic [ues_pkg::SENS_W-1:0] trigger_sensor,
	output logic [ues_pkg::DIST_W-1:0] distance,
	output logic                       measured,
	output logic                       sweep_done,
	output logic                       undetected
);
	import ues_pkg::*;

	typedef enum logic [1:0] {
		PH_RISE = 2'd0,
		PH_FALL = 2'd1,
		PH_DONE = 2'd2
	} phase_t;

	logic              valid_s1;
	cmd_t              cmd_s1;
	logic              rising_s1;
	logic [TS_W-1:0]   ts_s1;
	logic [SENS_W-1:0] sensor_s1;
	logic              advance;

	logic              busy_q, busy_d;
	phase_t            phase_q, phase_d;
	logic [TS_W-1:0]   start_q, start_d;
	logic [TS_W-1:0]   end_q, end_d;
	logic [SENS_W-1:0] trig_idx_q, trig_idx_d;
	logic [SENS_W-1:0] sweep_idx_q, sweep_idx_d;
	logic              undet_q, undet_d;

	logic [DIST_W-1:0] quot;
	logic [DIST_W-1:0] rd_data;
	store_ctl_t        st_ctl;

	logic              fire_r;
	logic [SENS_W-1:0] tsens_r;
	logic [DIST_W-1:0] dist_r;
	logic              meas_r;
	logic              done_r;

	logic              out_valid_q;
	logic              fire_q;
	logic [SENS_W-1:0] tsens_q;
	logic [DIST_W-1:0] dist_q;
	logic              meas_q;
	logic              done_q;
	logic              undet_out_q;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1    <= cmd_t'(cmd);
			rising_s1 <= edge_rising;
			ts_s1     <= timestamp;
			sensor_s1 <= sensor;
		end
	end

	ues_div58 u_div (
		.diff (end_q - start_q),
		.quot (quot)
	);

	ues_dist_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (st_ctl),
		.rd_sel  (sensor_s1),
		.rd_data (rd_data)
	);

	always_comb begin
		busy_d      = busy_q;
		phase_d     = phase_q;
		start_d     = start_q;
		end_d       = end_q;
		trig_idx_d  = trig_idx_q;
		sweep_idx_d = sweep_idx_q;
		undet_d     = undet_q;
		fire_r      = 1'b0;
		tsens_r     = '0;
		dist_r      = '0;
		meas_r      = 1'b0;
		done_r      = 1'b0;
		st_ctl      = '{wr: 1'b0, commit: 1'b0, slot: sweep_idx_q, data: quot};
		unique case (cmd_s1)
			CMD_TRIGGER: begin
				if (!busy_q) begin
					phase_d    = PH_RISE;
					fire_r     = 1'b1;
					tsens_r    = trig_idx_q;
					busy_d     = 1'b1;
					trig_idx_d = (32'(trig_idx_q) == NUM_SENSORS - 1) ? '0 : trig_idx_q + 1'b1;
				end
			end
			CMD_EDGE: begin
				if (busy_q) begin
					if (phase_q == PH_RISE && rising_s1) begin
						start_d = ts_s1;
						phase_d = PH_FALL;
					end else if (phase_q == PH_FALL && !rising_s1) begin
						end_d   = ts_s1;
						phase_d = PH_DONE;
					end
				end
			end
			CMD_CHECK: begin
				if (phase_q == PH_DONE) begin
					st_ctl.wr = 1'b1;
					busy_d    = 1'b0;
					dist_r    = quot;
					meas_r    = 1'b1;
					if (32'(sweep_idx_q) == NUM_SENSORS - 1) begin
						st_ctl.commit = 1'b1;
						sweep_idx_d   = '0;
						done_r        = 1'b1;
					end else begin
						sweep_idx_d = sweep_idx_q + 1'b1;
					end
				end else begin
					undet_d = 1'b1;
				end
			end
			CMD_READ: begin
				dist_r = rd_data;
			end
			default: begin
			end
		endcase
		if (!advance) begin
			st_ctl.wr = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			phase_q     <= PH_RISE;
			start_q     <= '0;
			end_q       <= '0;
			trig_idx_q  <= '0;
			sweep_idx_q <= '0;
			undet_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				busy_q      <= busy_d;
				phase_q     <= phase_d;
				start_q     <= start_d;
				end_q       <= end_d;
				trig_idx_q  <= trig_idx_d;
				sweep_idx_q <= sweep_idx_d;
				undet_q     <= undet_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fire_q      <= fire_r;
			tsens_q     <= tsens_r;
			dist_q      <= dist_r;
			meas_q      <= meas_r;
			done_q      <= done_r;
			undet_out_q <= undet_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign trigger_fire   = fire_q;
	assign trigger_sensor = tsens_q;
	assign distance       = dist_q;
	assign measured       = meas_q;
	assign sweep_done     = done_q;
	assign undetected     = undet_out_q;

endmodule

### bench/testbench.sv
// Self-checking testbench for the ultrasonic echo scanner core with a scoreboard class.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ues_pkg::*;

	localparam int ITEM_COUNT      = 400;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int MAX_REPORTS     = 10;

	typedef enum logic [1:0] {
		WAIT_RISE = 2'd0,
		WAIT_FALL = 2'd1,
		ECHO_DONE = 2'd2
	} capture_t;

	typedef struct packed {
		logic              fire;
		logic [SENS_W-1:0] fired_sensor;
		logic [DIST_W-1:0] dist_cm;
		logic              meas;
		logic              done;
		logic              undet;
	} echo_reading_t;

	class echo_scoreboard;
		logic                 busy;
		capture_t             phase;
		logic [TS_W-1:0]      rise_ts;
		logic [TS_W-1:0]      fall_ts;
		logic [SENS_W-1:0]    next_trigger;
		logic [SENS_W-1:0]    next_slot;
		logic [DIST_W-1:0]    sweep_buf [NUM_SENSORS];
		logic [DIST_W-1:0]    dist_table [NUM_SENSORS];
		logic                 undet;
		echo_reading_t        pending_readings [$];
		int unsigned          mismatches;

		function new();
			busy         = 1'b0;
			phase        = WAIT_RISE;
			rise_ts      = '0;
			fall_ts      = '0;
			next_trigger = '0;
			next_slot    = '0;
			undet        = 1'b0;
			mismatches   = 0;
			foreach (dist_table[i]) begin
				sweep_buf[i]  = '0;
				dist_table[i] = '0;
			end
		endfunction

		function void note_item(cmd_t c, logic rise, logic [TS_W-1:0] ts,
			logic [SENS_W-1:0] sel);
			echo_reading_t    r;
			logic [TS_W-1:0]  span;
			int unsigned      slot;
			r = '0;
			case (c)
			CMD_TRIGGER: begin
				if (!busy) begin
					phase          = WAIT_RISE;
					r.fire         = 1'b1;
					r.fired_sensor = next_trigger;
					busy           = 1'b1;
					next_trigger   = SENS_W'((next_trigger + 1) % NUM_SENSORS);
				end
			end
			CMD_EDGE: begin
				if (busy) begin
					if (phase == WAIT_RISE && rise) begin
						rise_ts = ts;
						phase   = WAIT_FALL;
					end else if (phase == WAIT_FALL && !rise) begin
						fall_ts = ts;
						phase   = ECHO_DONE;
					end
				end
			end
			CMD_CHECK: begin
				if (phase == ECHO_DONE) begin
					span            = fall_ts - rise_ts;
					slot            = next_slot % NUM_SENSORS;
					r.dist_cm       = DIST_W'(span / ECHO_DIVISOR);
					r.meas          = 1'b1;
					sweep_buf[slot] = r.dist_cm;
					busy            = 1'b0;
					if (slot + 1 >= NUM_SENSORS) begin
						next_slot  = '0;
						dist_table = sweep_buf;
						r.done     = 1'b1;
					end else begin
						next_slot = SENS_W'(slot + 1);
					end
				end else begin
					undet = 1'b1;
				end
			end
			default: begin
				if (sel < NUM_SENSORS)
					r.dist_cm = dist_table[sel];
			end
			endcase
			r.undet = undet;
			pending_readings.push_back(r);
		endfunction

		function void check_result(echo_reading_t got);
			echo_reading_t want;
			if (pending_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result with none pending: ", $realtime,
						"fire=%0d sensor=%0d dist=%0d ",
						got.fire, got.fired_sensor, got.dist_cm,
						"meas=%0d done=%0d undet=%0d",
						got.meas, got.done, got.undet);
				return;
			end
			want = pending_readings.pop_front();
			if (got.fire !== want.fire || got.fired_sensor !== want.fired_sensor ||
				got.dist_cm !== want.dist_cm || got.meas !== want.meas ||
				got.done !== want.done || got.undet !== want.undet) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: mismatch exp fire=%0d sensor=%0d dist=%0d ",
						$realtime, want.fire, want.fired_sensor, want.dist_cm,
						"meas=%0d done=%0d undet=%0d / ",
						want.meas, want.done, want.undet,
						"got fire=%0d sensor=%0d dist=%0d ",
						got.fire, got.fired_sensor, got.dist_cm,
						"meas=%0d done=%0d undet=%0d",
						got.meas, got.done, got.undet);
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        cmd = CMD_READ;
	logic              edge_rising = 1'b0;
	logic [TS_W-1:0]   timestamp = '0;
	logic [SENS_W-1:0] sensor = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              trigger_fire;
	logic [SENS_W-1:0] trigger_sensor;
	logic [DIST_W-1:0] distance;
	logic              measured;
	logic              sweep_done;
	logic              undetected;

	echo_scoreboard board = new();
	int unsigned    idle_pct = 0;
	int unsigned    items_sent = 0;
	int unsigned    cycles = 0;
	bit             hold_off_go = 1'b0;

	ultrasonic_echo_scanner_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.edge_rising    (edge_rising),
		.timestamp      (timestamp),
		.sensor         (sensor),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.trigger_fire   (trigger_fire),
		.trigger_sensor (trigger_sensor),
		.distance       (distance),
		.measured       (measured),
		.sweep_done     (sweep_done),
		.undetected     (undetected)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				board.check_result(echo_reading_t'{trigger_fire, trigger_sensor, distance,
					measured, sweep_done, undetected});
			if (in_valid && !in_stall)
				board.note_item(cmd_t'(cmd), edge_rising, timestamp, sensor);
		end
	end

	initial begin : receiver
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (hold_off_go) begin
				hold_off_go = 1'b0;
				stall_left  = HOLD_OFF_CYCLES - 1;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 99) < idle_pct) begin
				stall_left = $urandom_range(0, 3);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_item(cmd_t c, logic rise, logic [TS_W-1:0] ts, logic [SENS_W-1:0] sel);
		int unsigned gap;
		gap = 0;
		if ($urandom_range(0, 99) < idle_pct)
			gap = $urandom_range(1, 4);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		cmd         <= c;
		edge_rising <= rise;
		timestamp   <= ts;
		sensor      <= sel;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_cmd(cmd_t c);
		send_item(c, 1'($urandom), TS_W'($urandom), SENS_W'($urandom));
	endtask

	task automatic send_edge(logic rise, logic [TS_W-1:0] ts);
		send_item(CMD_EDGE, rise, ts, SENS_W'($urandom));
	endtask

	task automatic send_read(logic [SENS_W-1:0] sel);
		send_item(CMD_READ, 1'($urandom), TS_W'($urandom), sel);
	endtask

	initial begin : stimulus
		logic [TS_W-1:0] start_ts;
		logic [TS_W-1:0] span;
		int unsigned     pick;
		int unsigned     n;
		bit              hold_done;
		hold_done = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 30;
		send_read(2'd0);
		send_edge(1'b1, 16'h1234);
		send_cmd(CMD_TRIGGER);
		send_cmd(CMD_TRIGGER);
		send_edge(1'b0, 16'h0000);
		send_edge(1'b1, 16'h0000);
		send_edge(1'b1, 16'h5555);
		send_edge(1'b0, 16'hFFFF);
		send_edge(1'b0, 16'h0001);
		send_cmd(CMD_CHECK);
		send_cmd(CMD_CHECK);
		send_cmd(CMD_TRIGGER);
		send_edge(1'b1, 16'hFFC0);
		send_edge(1'b0, 16'h0040);
		send_cmd(CMD_CHECK);
		send_cmd(CMD_TRIGGER);
		send_edge(1'b1, 16'h8000);
		send_edge(1'b0, 16'h8000);
		send_cmd(CMD_CHECK);
		send_read(2'd3);
		send_read(2'd0);
		send_cmd(CMD_TRIGGER);
		send_cmd(CMD_CHECK);
		send_edge(1'b1, 16'h0039);
		send_edge(1'b0, 16'h0073);
		send_cmd(CMD_CHECK);
		send_read(2'd2);

		while (items_sent < ITEM_COUNT) begin
			if (items_sent >= ITEM_COUNT - 60) begin
				idle_pct = 0;
			end else if (items_sent >= 200) begin
				idle_pct = 20;
				if (!hold_done) begin
					hold_off_go = 1'b1;
					hold_done   = 1'b1;
				end
			end else if (items_sent >= 130) begin
				idle_pct = 0;
			end else begin
				idle_pct = 30;
			end

			pick = $urandom_range(0, 19);
			if (pick < 13) begin
				start_ts = TS_W'($urandom);
				case ($urandom_range(0, 3))
				0: span = TS_W'($urandom);
				1: span = TS_W'($urandom_range(0, 600));
				2: span = TS_W'($urandom_range(0, 1128) * ECHO_DIVISOR +
					($urandom_range(0, 1) ? ECHO_DIVISOR - 1 : 0));
				default: span = TS_W'($urandom_range(100, 23200));
				endcase
				send_cmd(CMD_TRIGGER);
				if ($urandom_range(0, 3) == 0)
					send_edge(1'b0, TS_W'($urandom));
				send_edge(1'b1, start_ts);
				if ($urandom_range(0, 4) == 0)
					send_edge(1'b1, TS_W'($urandom));
				send_edge(1'b0, start_ts + span);
				if ($urandom_range(0, 4) == 0)
					send_edge(1'($urandom), TS_W'($urandom));
				send_cmd(CMD_CHECK);
				if ($urandom_range(0, 7) == 0)
					send_cmd(CMD_CHECK);
				if ($urandom_range(0, 2) == 0)
					send_read(SENS_W'($urandom));
			end else if (pick < 16) begin
				n = $urandom_range(1, 3);
				repeat (n) send_read(SENS_W'($urandom));
			end else if (pick < 18) begin
				send_cmd(CMD_TRIGGER);
				if ($urandom_range(0, 1) == 0)
					send_edge(1'b1, TS_W'($urandom));
				send_cmd(CMD_CHECK);
			end else begin
				send_item(cmd_t'($urandom_range(0, 3)), 1'($urandom), TS_W'($urandom),
					SENS_W'($urandom));
			end
		end

		in_valid <= 1'b0;
		while (board.pending_readings.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (board.mismatches == 0 && board.pending_readings.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
